### hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by pip_ctrl, pip_dp and the top level.
package pip_pkg;

  // Polygon store geometry
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned COORD_WIDTH  = 24;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VTX_W        = 2 * COORD_WIDTH;

  // Fixed field widths
  localparam int unsigned VCNT_W = 7;
  localparam int unsigned SLOT_W = 6;

  // Edge arithmetic: coordinate differences and their exact products
  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;

  localparam int unsigned MIN_VERTICES = 3;
  localparam logic [VCNT_W-1:0] VCOUNT_RST = VCNT_W'(MIN_VERTICES);

  // Cycles from the last store read until the accumulators settle
  localparam int unsigned DRAIN_CYC = 3;
  localparam int unsigned DRAIN_W   = $clog2(DRAIN_CYC);

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } pip_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             start;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_edge;
    logic             publish;
  } pip_cmd_t;

endpackage

### hw/rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pip_ctrl.sv
// Controller for the point-in-polygon test: item handshake, vertex count
// register, edge walk sequencing and result publication. Depends on pip_pkg.
module pip_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [pip_pkg::SLOT_W-1:0]       vertex_index_i,
  input  logic                             cfg_we_i,
  input  logic [pip_pkg::VCNT_W-1:0]       cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pip_pkg::pip_cmd_t                cmd_o
);

  import pip_pkg::*;

  pip_state_e          state_q, state_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [DRAIN_W-1:0]  drain_q, drain_d;
  logic [VCNT_W-1:0]   vcount_q;
  logic                out_valid_q, out_valid_d;
  logic [CNT_W-1:0]    n_verts;
  logic                slot_ok;
  pip_cmd_t            cmd;

  // Clamp the programmed count into the supported range
  always_comb begin
    if (vcount_q < VCNT_W'(MIN_VERTICES)) begin
      n_verts = CNT_W'(MIN_VERTICES);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_verts = CNT_W'(MAX_VERTICES);
    end else begin
      n_verts = CNT_W'(vcount_q);
    end
  end

  assign slot_ok = 32'(vertex_index_i) < MAX_VERTICES;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (func_i == FUNC_QUERY)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (step_q == n_verts) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_q == DRAIN_W'(DRAIN_CYC - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.wr_addr = IDX_W'(vertex_index_i);
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (func_i == FUNC_QUERY) begin
            cmd.start = 1'b1;
          end else begin
            cmd.wr_en = slot_ok;
          end
        end
      end
      ST_WALK: begin
        // First read seeds the previous vertex with the last one
        cmd.rd_en   = 1'b1;
        cmd.rd_edge = (step_q != '0);
        if (step_q == '0) begin
          cmd.rd_addr = IDX_W'(n_verts - CNT_W'(1));
        end else begin
          cmd.rd_addr = IDX_W'(step_q - CNT_W'(1));
        end
      end
      ST_DRAIN: begin
        cmd = cmd;
      end
      ST_DONE: begin
        cmd.publish = !out_valid_q || !out_stall_i;
      end
      default: begin
        cmd = cmd;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (cmd.start) begin
      step_d = '0;
    end else if (state_q == ST_WALK) begin
      step_d = step_q + CNT_W'(1);
    end
  end

  always_comb begin
    drain_d = drain_q;
    if (state_q == ST_WALK) begin
      drain_d = '0;
    end else if (state_q == ST_DRAIN) begin
      drain_d = drain_q + DRAIN_W'(1);
    end
  end

  // Hold a result until its transfer, then drop it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      drain_q     <= '0;
      vcount_q    <= VCOUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/pip_dp.sv
// Datapath for the point-in-polygon test: vertex store, edge test pipeline
// (differences, products, compare) and parity/boundary accumulation.
// Depends on pip_pkg and pip_ram.
module pip_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pip_pkg::pip_cmd_t                      cmd_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y_i,
  output logic                                   inside_res_o,
  output logic                                   on_boundary_o
);

  import pip_pkg::*;

  logic [VTX_W-1:0]               rdata;
  logic signed [COORD_WIDTH-1:0]  px_q, py_q, ax_q, ay_q, bx, by;
  logic                           rd_v_q, rd_edge_q;

  // Stage A: differences and flags
  logic signed [DIFF_W-1:0] dxe_d, dyp_d, dye_d, dxp_d;
  logic signed [DIFF_W-1:0] dxe_q, dyp_q, dye_q, dxp_q;
  logic                     box_d, strad_d, dypos_d;
  logic                     box_q, strad_q, dypos_q, a_v_q;

  // Stage B: products
  logic signed [PROD_W-1:0] p1_d, p2_d, p1_q, p2_q;
  logic                     box_b_q, strad_b_q, dypos_b_q, b_v_q;

  // Stage C: accumulate
  logic hit, tog;
  logic bnd_q, par_q;
  logic inside_q, onb_q;

  pip_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign bx = rdata[VTX_W-1 -: COORD_WIDTH];
  assign by = rdata[COORD_WIDTH-1:0];

  always_comb begin
    dxe_d   = DIFF_W'(bx) - DIFF_W'(ax_q);
    dye_d   = DIFF_W'(by) - DIFF_W'(ay_q);
    dxp_d   = DIFF_W'(px_q) - DIFF_W'(ax_q);
    dyp_d   = DIFF_W'(py_q) - DIFF_W'(ay_q);
    box_d   = ((px_q >= ax_q && px_q <= bx) || (px_q >= bx && px_q <= ax_q)) &&
              ((py_q >= ay_q && py_q <= by) || (py_q >= by && py_q <= ay_q));
    strad_d = (ay_q > py_q) != (by > py_q);
    dypos_d = by > ay_q;
  end

  assign p1_d = dxe_q * dyp_q;
  assign p2_d = dye_q * dxp_q;

  // Equal products inside the box: the point lies on the edge
  assign hit = (p1_q == p2_q) && box_b_q;
  assign tog = strad_b_q && !hit && (dypos_b_q ? (p2_q < p1_q) : (p1_q < p2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q    <= 1'b0;
      rd_edge_q <= 1'b0;
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      bnd_q     <= 1'b0;
      par_q     <= 1'b0;
    end else begin
      rd_v_q    <= cmd_i.rd_en;
      rd_edge_q <= cmd_i.rd_en && cmd_i.rd_edge;
      a_v_q     <= rd_edge_q;
      b_v_q     <= a_v_q;
      if (cmd_i.start) begin
        bnd_q <= 1'b0;
        par_q <= 1'b0;
      end else if (b_v_q) begin
        bnd_q <= bnd_q | hit;
        par_q <= par_q ^ tog;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    // Advance the previous vertex on every returned read
    if (rd_v_q) begin
      ax_q <= bx;
      ay_q <= by;
    end
    dxe_q     <= dxe_d;
    dye_q     <= dye_d;
    dxp_q     <= dxp_d;
    dyp_q     <= dyp_d;
    box_q     <= box_d;
    strad_q   <= strad_d;
    dypos_q   <= dypos_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    box_b_q   <= box_q;
    strad_b_q <= strad_q;
    dypos_b_q <= dypos_q;
    if (cmd_i.publish) begin
      inside_q <= bnd_q | par_q;
      onb_q    <= bnd_q;
    end
  end

  assign inside_res_o  = inside_q;
  assign on_boundary_o = onb_q;

endmodule

### hw/rtl/point_in_polygon_test.sv
// Point-in-polygon test block, top level: joins the controller and datapath.
// Depends on pip_pkg, pip_ctrl, pip_dp (and pip_ram below it).
//
// Holds a polygon of up to MAX_VERTICES signed fixed-point vertices (8
// fractional bits) and answers whether a query point lies inside it. An input
// item with func = 0 writes one vertex slot and produces no result; one with
// func = 1 is a query and produces exactly one result carrying inside_res and
// on_boundary. A point on any edge counts as inside; otherwise the even-odd
// crossing rule decides, with all tests exact (cross products at full width).
// vertex_count sets how many slots form the polygon, clamped to 3 ..
// MAX_VERTICES; write it only while the block is idle. Vertex slots hold
// nothing defined until loaded, so load every slot in use before querying.
// For a query with n vertices in use, the edge walk reads one vertex per
// cycle from the vertex store, n + 1 reads in all, followed by a three-stage
// edge test pipeline (differences, two 25x25 products, compare) that must
// drain. One query is in flight at a time; the finished result sits in an
// output register, so the next item is taken while the previous result
// waits for its transfer. The vertex store needs no clearing pass after reset.
module point_in_polygon_test (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic [pip_pkg::SLOT_W-1:0]             vertex_index_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y_i,
  // Configuration: vertex_count
  input  logic                                   cfg_we_i,
  input  logic [pip_pkg::VCNT_W-1:0]             cfg_data_i,
  // Result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   inside_res_o,
  output logic                                   on_boundary_o
);

  import pip_pkg::*;

  pip_cmd_t cmd;

  // Sequence loads and the edge walk; own the handshake and count register
  pip_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .vertex_index_i (vertex_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd)
  );

  // Store vertices, test each edge, accumulate parity and boundary hits
  pip_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .inside_res_o  (inside_res_o),
    .on_boundary_o (on_boundary_o)
  );

`ifndef ASSERT_OFF
  // A query transfer occupies the block on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (func_i == FUNC_QUERY)) |=> in_stall_o)
    else $error("query accepted but input not stalled");

  // A load transfer leaves the block ready for the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (func_i == FUNC_LOAD)) |=> !in_stall_o)
    else $error("load transfer left the input stalled");

  // A new result only appears at the end of a query walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised without a query in progress");

  // Results appear only as the walk finishes and the block turns idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while block still busy");
`endif

endmodule
